### sv/cods_pkg.sv
`default_nettype none

package cods_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned CORR_W   = 20;
  localparam int unsigned RANGE_W  = 18;
  localparam int unsigned HIGH_W   = 15;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic [2:0] REG_CLIP_HIGH  = 3'd0;
  localparam logic [2:0] REG_CLIP_LOW   = 3'd1;
  localparam logic [2:0] REG_CLIP_LIMIT = 3'd2;
  localparam logic [2:0] REG_MAX_DEPTH  = 3'd3;
  localparam logic [2:0] REG_CORR_RANGE = 3'd4;

  localparam logic [HIGH_W-1:0]         CLIP_HIGH_RST  = 15'd28000;
  localparam logic signed [SAMPLE_W-1:0] CLIP_LOW_RST  = -16'sd28000;
  localparam logic [CNT_W-1:0]          CLIP_LIMIT_RST = 7'd20;
  localparam logic [STEP_W-1:0]         MAX_DEPTH_RST  = 4'd12;
  localparam logic [RANGE_W-1:0]        CORR_RANGE_RST = 18'd4096;

  localparam logic [CNT_W-1:0]  CNT_MAX  = 7'd127;
  localparam logic [STEP_W-1:0] STEP_MAX = 4'd15;

  typedef enum logic [4:0] {
    PH_PROBE   = 5'b00001,
    PH_INITIAL = 5'b00010,
    PH_BEGIN   = 5'b00100,
    PH_SEARCH  = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BOTH  = 2'd1,
    ST_DEPTH = 2'd2
  } status_t;

  typedef struct packed {
    logic [HIGH_W-1:0]          clip_high;
    logic signed [SAMPLE_W-1:0] clip_low;
    logic [CNT_W-1:0]           clip_limit;
    logic [STEP_W-1:0]          max_depth;
    logic [RANGE_W-1:0]         corr_range;
  } cfg_t;

  typedef struct packed {
    logic top;
    logic bot;
    logic both;
  } clip_flags_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correction;
    logic                     done_res;
    status_t                  status;
  } result_t;

  function automatic logic signed [CORR_W-1:0] midpoint(
    input logic signed [CORR_W-1:0] a,
    input logic signed [CORR_W-1:0] b
  );
    logic signed [CORR_W:0] sum;
    sum = {a[CORR_W-1], a} + {b[CORR_W-1], b};
    return sum[CORR_W:1];
  endfunction

endpackage

`default_nettype wire

### sv/cods_if.sv
`default_nettype none

interface cods_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   sample;
  logic                 window_last;
  logic                 restart;

  modport source (output valid, sample, window_last, restart, input ready);
  modport sink   (input valid, sample, window_last, restart, output ready);
endinterface

interface cods_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [19:0]   correction;
  logic                 done_res;
  logic [1:0]           status;

  modport source (output valid, correction, done_res, status, input ready);
  modport sink   (input valid, correction, done_res, status, output ready);
endinterface

`default_nettype wire

### sv/clip_driven_offset_search.sv
// Clip-driven offset correction search.
// in_chan carries signed samples with window_last and restart flags; out_chan
// carries one result (correction, done_res, status) for every sample that
// closes a window. Samples that do not close a window produce no transfer.
// Registers are written through the APB port (clip_high 0x00, clip_low 0x04,
// clip_limit 0x08, max_depth 0x0C, correction_range 0x10), pready is always
// high, and writes belong only in idle periods.
// A sample is held in the input register while the count and search logic
// update from it; a window's result is captured in the output register as
// that sample advances, and out_chan.valid is driven from that register.
// Throughput: one sample per cycle unless a pending result is held by a low
// out_chan.ready, bounded by the count and bisection update in cods_clip_cnt and cods_search.
// Reset (rst_n low, synchronous) loads the register defaults, clears counts,
// bounds and offset and puts the search in probe.
// When out_chan.ready is low with a result pending, the input register holds
// and in_chan.ready drops once that register is full; nothing is dropped.
`default_nettype none

module clip_driven_offset_search (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  cods_in_if.sink                          in_chan,
  cods_out_if.source                       out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cods_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cods_pkg::DATA_W-1:0] pwdata,
  output logic [cods_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  cods_pkg::cfg_t        cfg;
  cods_pkg::clip_flags_t flags;
  cods_pkg::result_t     result;

  logic                                in_v_r;
  logic signed [cods_pkg::SAMPLE_W-1:0] sample_r;
  logic                                last_r;
  logic                                restart_r;
  logic                                out_v_r, out_v_nxt;
  cods_pkg::result_t                   res_r;
  logic                                advance;
  logic                                active;
  logic                                in_take;

  assign advance       = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r  <= in_chan.sample;
      last_r    <= in_chan.window_last;
      restart_r <= in_chan.restart;
    end
  end

  cods_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cods_clip_cnt u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .restart (restart_r),
    .last    (last_r),
    .active  (active),
    .sample  (sample_r),
    .cfg     (cfg),
    .flags   (flags)
  );

  cods_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .restart (restart_r),
    .last    (last_r),
    .cfg     (cfg),
    .flags   (flags),
    .active  (active),
    .result  (result)
  );

  always_comb begin
    if (advance && last_r) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      res_r <= result;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.correction = res_r.correction;
  assign out_chan.done_res   = res_r.done_res;
  assign out_chan.status     = res_r.status;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.status != cods_pkg::ST_OK |-> res_r.correction == '0)
    else $error("failed search reports nonzero correction");

  a_busy_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_r.done_res |-> res_r.status == cods_pkg::ST_OK)
    else $error("unfinished search reports a failure");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(sample_r) && $stable(last_r))
    else $error("input register lost a stalled sample");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(advance && last_r))
    else $error("result without a window end");
`endif

endmodule

`default_nettype wire

### sv/cods_cfg.sv
`default_nettype none

module cods_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cods_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [cods_pkg::DATA_W-1:0]   pwdata,
  output logic [cods_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  output cods_pkg::cfg_t                     cfg
);

  cods_pkg::cfg_t cfg_r;
  cods_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        cods_pkg::REG_CLIP_HIGH:  cfg_nxt.clip_high  = pwdata[cods_pkg::HIGH_W-1:0];
        cods_pkg::REG_CLIP_LOW:   cfg_nxt.clip_low   = $signed(pwdata[cods_pkg::SAMPLE_W-1:0]);
        cods_pkg::REG_CLIP_LIMIT: cfg_nxt.clip_limit = pwdata[cods_pkg::CNT_W-1:0];
        cods_pkg::REG_MAX_DEPTH:  cfg_nxt.max_depth  = pwdata[cods_pkg::STEP_W-1:0];
        cods_pkg::REG_CORR_RANGE: cfg_nxt.corr_range = pwdata[cods_pkg::RANGE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_high  <= cods_pkg::CLIP_HIGH_RST;
      cfg_r.clip_low   <= cods_pkg::CLIP_LOW_RST;
      cfg_r.clip_limit <= cods_pkg::CLIP_LIMIT_RST;
      cfg_r.max_depth  <= cods_pkg::MAX_DEPTH_RST;
      cfg_r.corr_range <= cods_pkg::CORR_RANGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      cods_pkg::REG_CLIP_HIGH:  prdata = {17'd0, cfg_r.clip_high};
      cods_pkg::REG_CLIP_LOW:   prdata = {{16{cfg_r.clip_low[15]}}, cfg_r.clip_low};
      cods_pkg::REG_CLIP_LIMIT: prdata = {25'd0, cfg_r.clip_limit};
      cods_pkg::REG_MAX_DEPTH:  prdata = {28'd0, cfg_r.max_depth};
      cods_pkg::REG_CORR_RANGE: prdata = {14'd0, cfg_r.corr_range};
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/cods_clip_cnt.sv
`default_nettype none

module cods_clip_cnt (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               advance,
  input  wire logic                               restart,
  input  wire logic                               last,
  input  wire logic                               active,
  input  wire logic signed [cods_pkg::SAMPLE_W-1:0] sample,
  input  wire cods_pkg::cfg_t                     cfg,
  output cods_pkg::clip_flags_t                   flags
);

  logic [cods_pkg::CNT_W-1:0] hc_r, hc_nxt, lc_r, lc_nxt;
  logic                       bc_r, bc_nxt;
  logic [cods_pkg::CNT_W-1:0] hc_b, lc_b, hc_n, lc_n;
  logic                       bc_b, bc_n;
  logic                       hi_hit, lo_hit;

  assign hi_hit = sample > $signed({1'b0, cfg.clip_high});
  assign lo_hit = sample < cfg.clip_low;

  always_comb begin
    hc_b = restart ? '0 : hc_r;
    lc_b = restart ? '0 : lc_r;
    bc_b = restart ? 1'b0 : bc_r;
    hc_n = hc_b;
    lc_n = lc_b;
    bc_n = bc_b;
    if (active) begin
      if (hc_b < cfg.clip_limit && hc_b < cods_pkg::CNT_MAX && hi_hit) begin
        hc_n = hc_b + 7'd1;
      end
      if (lc_b < cfg.clip_limit && lc_b < cods_pkg::CNT_MAX && lo_hit) begin
        lc_n = lc_b + 7'd1;
      end
      if (hc_n >= cfg.clip_limit && lc_n >= cfg.clip_limit) begin
        bc_n = 1'b1;
      end
    end
    flags.top  = hc_n >= cfg.clip_limit;
    flags.bot  = lc_n >= cfg.clip_limit;
    flags.both = bc_n;
    hc_nxt = last ? '0 : hc_n;
    lc_nxt = last ? '0 : lc_n;
    bc_nxt = last ? 1'b0 : bc_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= '0;
      lc_r <= '0;
      bc_r <= 1'b0;
    end else if (advance) begin
      hc_r <= hc_nxt;
      lc_r <= lc_nxt;
      bc_r <= bc_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/cods_search.sv
`default_nettype none

module cods_search (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire logic                  restart,
  input  wire logic                  last,
  input  wire cods_pkg::cfg_t        cfg,
  input  wire cods_pkg::clip_flags_t flags,
  output logic                       active,
  output cods_pkg::result_t          result
);

  cods_pkg::phase_t                       ph_r, ph_nxt, ph_b;
  cods_pkg::status_t                      fail_r, fail_nxt, fail_b;
  logic [cods_pkg::STEP_W-1:0]            step_r, step_nxt, step_b, step_inc;
  logic signed [cods_pkg::CORR_W-1:0]     lo_r, lo_nxt, lo_b;
  logic signed [cods_pkg::CORR_W-1:0]     up_r, up_nxt, up_b;
  logic signed [cods_pkg::CORR_W-1:0]     off_r, off_nxt;
  logic signed [cods_pkg::CORR_W-1:0]     half, lo_s, up_s;

  assign half = $signed({3'b000, cfg.corr_range[cods_pkg::RANGE_W-1:1]});

  always_comb begin
    ph_b     = restart ? cods_pkg::PH_PROBE : ph_r;
    fail_b   = restart ? cods_pkg::ST_OK : fail_r;
    step_b   = restart ? '0 : step_r;
    lo_b     = restart ? '0 : lo_r;
    up_b     = restart ? '0 : up_r;
    active   = ph_b != cods_pkg::PH_DONE;
    step_inc = (step_b == cods_pkg::STEP_MAX) ? step_b : step_b + 4'd1;
    lo_s     = flags.top ? off_r : lo_b;
    up_s     = flags.top ? up_b : off_r;

    ph_nxt   = ph_b;
    fail_nxt = fail_b;
    step_nxt = step_b;
    lo_nxt   = lo_b;
    up_nxt   = up_b;
    off_nxt  = off_r;

    if (last && active) begin
      if (flags.both) begin
        off_nxt  = '0;
        fail_nxt = cods_pkg::ST_BOTH;
        ph_nxt   = cods_pkg::PH_DONE;
      end else begin
        case (ph_b)
          cods_pkg::PH_PROBE: begin
            if (!flags.top && !flags.bot) begin
              ph_nxt = cods_pkg::PH_DONE;
            end else begin
              off_nxt = '0;
              ph_nxt  = cods_pkg::PH_INITIAL;
            end
          end
          cods_pkg::PH_INITIAL: begin
            if (flags.top) begin
              off_nxt = half;
              lo_nxt  = '0;
              up_nxt  = half;
              ph_nxt  = cods_pkg::PH_BEGIN;
            end else if (flags.bot) begin
              off_nxt = -half;
              lo_nxt  = -half;
              up_nxt  = '0;
              ph_nxt  = cods_pkg::PH_BEGIN;
            end else begin
              ph_nxt = cods_pkg::PH_DONE;
            end
          end
          cods_pkg::PH_BEGIN: begin
            off_nxt = cods_pkg::midpoint(lo_b, up_b);
            ph_nxt  = cods_pkg::PH_SEARCH;
          end
          cods_pkg::PH_SEARCH: begin
            if (!flags.top && !flags.bot) begin
              ph_nxt = cods_pkg::PH_DONE;
            end else begin
              lo_nxt   = lo_s;
              up_nxt   = up_s;
              step_nxt = step_inc;
              if (step_inc >= cfg.max_depth) begin
                off_nxt  = '0;
                fail_nxt = cods_pkg::ST_DEPTH;
                ph_nxt   = cods_pkg::PH_DONE;
              end else begin
                off_nxt = cods_pkg::midpoint(lo_s, up_s);
              end
            end
          end
          default: ph_nxt = cods_pkg::PH_DONE;
        endcase
      end
    end

    result.correction = off_nxt;
    result.done_res   = ph_nxt == cods_pkg::PH_DONE;
    result.status     = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= cods_pkg::PH_PROBE;
      fail_r <= cods_pkg::ST_OK;
      step_r <= '0;
      lo_r   <= '0;
      up_r   <= '0;
      off_r  <= '0;
    end else if (advance) begin
      ph_r   <= ph_nxt;
      fail_r <= fail_nxt;
      step_r <= step_nxt;
      lo_r   <= lo_nxt;
      up_r   <= up_nxt;
      off_r  <= off_nxt;
    end
  end

endmodule

`default_nettype wire

### sim/tb_clip_driven_offset_search.sv
`default_nettype none

module tb_clip_driven_offset_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 150;
  localparam int TARGET_ITEMS = 650;
  localparam int MAX_REPORTS = 100;

  typedef enum {K_MID, K_HIGH, K_LOW, K_BOTH, K_NOISE} win_kind_t;

  class offset_search_sb;
    logic [cods_pkg::HIGH_W-1:0]          clip_high;
    logic signed [cods_pkg::SAMPLE_W-1:0] clip_low;
    logic [cods_pkg::CNT_W-1:0]           clip_limit;
    logic [cods_pkg::STEP_W-1:0]          max_depth;
    logic [cods_pkg::RANGE_W-1:0]         corr_range;

    logic [cods_pkg::CNT_W-1:0]         high_cnt;
    logic [cods_pkg::CNT_W-1:0]         low_cnt;
    logic                               both_hit;
    cods_pkg::phase_t                   phase;
    logic [cods_pkg::STEP_W-1:0]        steps;
    logic signed [cods_pkg::CORR_W-1:0] lower;
    logic signed [cods_pkg::CORR_W-1:0] upper;
    logic signed [cods_pkg::CORR_W-1:0] offset;
    cods_pkg::status_t                  fail;
    cods_pkg::result_t                  expected_q[$];
    int                                 errors;

    function new();
      clip_high  = cods_pkg::CLIP_HIGH_RST;
      clip_low   = cods_pkg::CLIP_LOW_RST;
      clip_limit = cods_pkg::CLIP_LIMIT_RST;
      max_depth  = cods_pkg::MAX_DEPTH_RST;
      corr_range = cods_pkg::CORR_RANGE_RST;
      offset     = '0;
      errors     = 0;
      clear_search();
    endfunction

    function void clear_search();
      high_cnt = '0;
      low_cnt  = '0;
      both_hit = 1'b0;
      phase    = cods_pkg::PH_PROBE;
      steps    = '0;
      lower    = '0;
      upper    = '0;
      fail     = cods_pkg::ST_OK;
    endfunction

    function logic signed [cods_pkg::CORR_W-1:0] floor_mid(
      logic signed [cods_pkg::CORR_W-1:0] a,
      logic signed [cods_pkg::CORR_W-1:0] b);
      logic signed [cods_pkg::CORR_W:0] sum;
      sum = a + b;
      return sum[cods_pkg::CORR_W:1];
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s", $time, msg);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        cods_pkg::REG_CLIP_HIGH:  clip_high  = v[cods_pkg::HIGH_W-1:0];
        cods_pkg::REG_CLIP_LOW:   clip_low   = v[cods_pkg::SAMPLE_W-1:0];
        cods_pkg::REG_CLIP_LIMIT: clip_limit = v[cods_pkg::CNT_W-1:0];
        cods_pkg::REG_MAX_DEPTH:  max_depth  = v[cods_pkg::STEP_W-1:0];
        cods_pkg::REG_CORR_RANGE: corr_range = v[cods_pkg::RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [cods_pkg::SAMPLE_W-1:0] s, logic last,
                              logic rs);
      logic top;
      logic bot;
      logic signed [cods_pkg::CORR_W-1:0] half;
      cods_pkg::result_t r;
      if (rs)
        clear_search();
      if (phase != cods_pkg::PH_DONE) begin
        if (high_cnt < clip_limit && high_cnt != cods_pkg::CNT_MAX &&
            int'(s) > int'(clip_high))
          high_cnt++;
        if (low_cnt < clip_limit && low_cnt != cods_pkg::CNT_MAX &&
            int'(s) < int'(clip_low))
          low_cnt++;
        if (high_cnt >= clip_limit && low_cnt >= clip_limit)
          both_hit = 1'b1;
      end
      if (!last)
        return;
      if (phase != cods_pkg::PH_DONE) begin
        top  = high_cnt >= clip_limit;
        bot  = low_cnt >= clip_limit;
        half = {3'b000, corr_range[cods_pkg::RANGE_W-1:1]};
        if (both_hit) begin
          offset = '0;
          fail   = cods_pkg::ST_BOTH;
          phase  = cods_pkg::PH_DONE;
        end else begin
          case (phase)
            cods_pkg::PH_PROBE: begin
              if (!top && !bot) begin
                phase = cods_pkg::PH_DONE;
              end else begin
                offset = '0;
                phase  = cods_pkg::PH_INITIAL;
              end
            end
            cods_pkg::PH_INITIAL: begin
              if (top) begin
                offset = half;
                lower  = '0;
                upper  = half;
                phase  = cods_pkg::PH_BEGIN;
              end else if (bot) begin
                offset = -half;
                lower  = -half;
                upper  = '0;
                phase  = cods_pkg::PH_BEGIN;
              end else begin
                phase = cods_pkg::PH_DONE;
              end
            end
            cods_pkg::PH_BEGIN: begin
              offset = floor_mid(lower, upper);
              phase  = cods_pkg::PH_SEARCH;
            end
            cods_pkg::PH_SEARCH: begin
              if (!top && !bot) begin
                phase = cods_pkg::PH_DONE;
              end else begin
                if (top)
                  lower = offset;
                else
                  upper = offset;
                offset = floor_mid(lower, upper);
                if (steps != cods_pkg::STEP_MAX)
                  steps++;
                if (steps >= max_depth) begin
                  offset = '0;
                  fail   = cods_pkg::ST_DEPTH;
                  phase  = cods_pkg::PH_DONE;
                end
              end
            end
            default: phase = cods_pkg::PH_DONE;
          endcase
        end
      end
      high_cnt = '0;
      low_cnt  = '0;
      both_hit = 1'b0;
      r.correction = offset;
      r.done_res   = (phase == cods_pkg::PH_DONE);
      r.status     = fail;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [cods_pkg::CORR_W-1:0] corr, logic done,
                               logic [1:0] st);
      cods_pkg::result_t e;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result: correction %0d done_res %0b status %0d",
                       corr, done, st));
        return;
      end
      e = expected_q.pop_front();
      if (corr !== e.correction)
        flag($sformatf("correction mismatch: expected %0d, actual %0d",
                       $signed(e.correction), corr));
      if (done !== e.done_res)
        flag($sformatf("done_res mismatch: expected %0b, actual %0b", e.done_res, done));
      if (st !== e.status)
        flag($sformatf("status mismatch: expected %0d, actual %0d", e.status, st));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cods_pkg::ADDR_W-1:0] paddr;
  logic [cods_pkg::DATA_W-1:0] pwdata;
  logic [cods_pkg::DATA_W-1:0] prdata;
  logic pready;

  cods_in_if  in_if ();
  cods_out_if out_if ();

  offset_search_sb sb = new();
  int items = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req = 1'b0;

  clip_driven_offset_search u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("tb_clip_driven_offset_search failed");
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_if.ready <= rx_steady || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.correction, out_if.done_res, out_if.status);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
  endtask

  task automatic set_config(int ch, int cl, int lim, int depth, int span);
    write_reg(cods_pkg::REG_CLIP_HIGH, ch);
    write_reg(cods_pkg::REG_CLIP_LOW, cl);
    write_reg(cods_pkg::REG_CLIP_LIMIT, lim);
    write_reg(cods_pkg::REG_MAX_DEPTH, depth);
    write_reg(cods_pkg::REG_CORR_RANGE, span);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_item(logic signed [cods_pkg::SAMPLE_W-1:0] s, logic last, logic rs);
    if (!tx_steady && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.window_last <= last;
    in_if.restart     <= rs;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(s, last, rs);
    items++;
  endtask

  function automatic logic signed [cods_pkg::SAMPLE_W-1:0] pick_sample(win_kind_t k);
    int t;
    int lo;
    int hi;
    case (k)
      K_HIGH: begin
        lo = int'(sb.clip_high) + 1;
        if (lo > 32767)
          lo = 32767;
        t = int'($urandom_range(32767, lo));
      end
      K_LOW: begin
        hi = int'(sb.clip_low) - 1;
        if (hi < -32768)
          hi = -32768;
        t = -32768 + int'($urandom_range(hi + 32768));
      end
      K_MID: t = int'(sb.clip_low) +
                 int'($urandom_range(int'(sb.clip_high) - int'(sb.clip_low)));
      default: t = int'($urandom_range(16'hFFFF));
    endcase
    return t[cods_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic send_window(win_kind_t kind, bit rs);
    int n;
    int rs_at;
    win_kind_t k;
    n = int'(sb.clip_limit) * (kind == K_BOTH ? 2 : 1) + $urandom_range(3);
    if (n == 0)
      n = 1;
    rs_at = rs ? 0 : ($urandom_range(99) < 3 ? int'($urandom_range(n - 1)) : -1);
    for (int i = 0; i < n; i++) begin
      if (kind == K_BOTH)
        k = (i % 2) ? K_LOW : K_HIGH;
      else if (kind == K_HIGH || kind == K_LOW)
        k = (i < int'(sb.clip_limit) || $urandom_range(1)) ? kind : K_MID;
      else
        k = kind;
      send_item(pick_sample(k), i == n - 1, i == rs_at);
    end
  endtask

  task automatic run_windows(int count);
    int r;
    win_kind_t w;
    bit rs;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(99);
      if (r < 45)
        w = K_HIGH;
      else if (r < 90)
        w = K_LOW;
      else if (r < 94)
        w = K_MID;
      else if (r < 96)
        w = K_BOTH;
      else
        w = K_NOISE;
      rs = (sb.phase == cods_pkg::PH_DONE && $urandom_range(99) < 80) ||
           $urandom_range(99) < 3;
      send_window(w, rs);
    end
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.window_last <= 1'b0;
    in_if.restart     <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(28000, -28000, 1, 2, 262143);
    send_item(16'sh7FFF, 1'b1, 1'b1);
    send_item(16'sh7FFF, 1'b1, 1'b0);
    send_item('0, 1'b1, 1'b0);
    send_item(16'sh7FFF, 1'b1, 1'b0);
    send_item(-16'sh8000, 1'b1, 1'b0);
    send_item(-16'sh8000, 1'b1, 1'b0);
    send_item(16'sh7FFF, 1'b0, 1'b1);
    send_item(-16'sh8000, 1'b1, 1'b0);
    send_item(-16'sh8000, 1'b1, 1'b1);
    send_item(-16'sh8000, 1'b1, 1'b0);
    send_item('0, 1'b1, 1'b0);
    send_item('0, 1'b1, 1'b0);
    send_item('0, 1'b1, 1'b0);
    send_item('0, 1'b1, 1'b1);
    send_item(16'sh7FFF, 1'b1, 1'b1);
    send_item('0, 1'b0, 1'b0);
    send_item('0, 1'b1, 1'b0);
    wait_idle();
    set_config(0, 0, 0, 0, 0);
    send_item(16'sd5, 1'b1, 1'b1);
    send_item('0, 1'b1, 1'b0);
    wait_idle();
    set_config(0, 0, 1, 0, 2);
    send_item(16'sd1, 1'b1, 1'b1);
    send_item(16'sd1, 1'b1, 1'b0);
    send_item('0, 1'b1, 1'b0);
    send_item(-16'sd1, 1'b1, 1'b0);

    wait_idle();
    set_config(28000, -28000, 20, 12, 4096);
    run_windows(6);
    wait_idle();
    set_config(32767, -32768, 3, 15, 1000);
    run_windows(8);
    wait_idle();
    set_config(100, -100, 2, 15, 262143);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_windows(25);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_idle();
    set_config(200, -300, 4, 8, 50000);
    hold_req = 1'b1;
    run_windows(15);
    wait_idle();
    set_config(12345, -5000, 64, 3, 77777);
    run_windows(2);
    while (items < TARGET_ITEMS) begin
      wait_idle();
      set_config($urandom_range(32767), -int'($urandom_range(32768)), $urandom_range(6, 1),
                 $urandom_range(15, 1), $urandom_range(262143));
      run_windows(12);
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb_clip_driven_offset_search passed");
    else
      $display("tb_clip_driven_offset_search failed");
    $finish;
  end

endmodule

`default_nettype wire
